### sv/npag_pkg.sv
package npag_pkg;

    localparam int MAX_RANK  = 4;
    localparam int DIM_BITS  = 12;
    localparam int AX_BITS   = 2;
    localparam int IDX_W     = 48;
    localparam int BYTE_W    = 51;
    localparam int RANK_W    = 3;
    localparam int EB_W      = 4;
    localparam int AXES_W    = 8;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = $clog2(IDX_W);
    localparam int RIDX_W    = $clog2(MAX_RANK);

    localparam logic [RANK_W-1:0] RANK_RST   = 3'd2;
    localparam logic [CFG_W-1:0]  DIMS_RST   = 48'd68736258049;
    localparam logic [AXES_W-1:0] AXES_RST   = 8'd0;
    localparam logic [EB_W-1:0]   EBYTES_RST = 4'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANK   = 2'd0,
        REG_DIMS   = 2'd1,
        REG_AXES   = 2'd2,
        REG_EBYTES = 2'd3
    } reg_idx_t;

    typedef logic [AX_BITS-1:0]  axis_t;
    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [IDX_W-1:0]    idx_t;

    typedef struct packed {
        logic                      busy;
        logic [RANK_W-1:0]         rank;
        logic                      bad;
        logic [EB_W-1:0]           ebytes;
        axis_t [MAX_RANK-1:0]      ax;
        dim_t  [MAX_RANK-1:0]      od;
        idx_t  [MAX_RANK-1:0]      src;
        idx_t  [MAX_RANK-1:0]      dst;
        idx_t                      total;
    } geom_t;

    typedef struct packed {
        logic op;
        idx_t position;
    } item_t;

endpackage

### sv/npag_cfg.sv
module npag_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [npag_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [npag_pkg::CFG_W-1:0]            cfg_data,
    output npag_pkg::geom_t                       geom
);
    import npag_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_STEP} cstate_t;

    cstate_t                 state_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic [CFG_W-1:0]        dims_reg;
    logic [AXES_W-1:0]       axes_reg;
    logic [EB_W-1:0]         eb_reg;
    logic [RIDX_W-1:0]       k_reg;
    logic [RANK_W-1:0]       r_reg;
    logic                    bad_reg;
    logic [EB_W-1:0]         ebytes_reg;
    axis_t [MAX_RANK-1:0]    ax_reg;
    dim_t  [MAX_RANK-1:0]    od_reg;
    dim_t  [MAX_RANK-1:0]    indim_reg;
    idx_t  [MAX_RANK-1:0]    src_reg;
    idx_t  [MAX_RANK-1:0]    dst_reg;
    idx_t                    total_reg;

    logic [RANK_W-1:0]       r;
    dim_t  [MAX_RANK-1:0]    indim;
    axis_t [MAX_RANK-1:0]    raw;
    axis_t [MAX_RANK-1:0]    ax;
    dim_t  [MAX_RANK-1:0]    od;
    logic                    any;
    logic                    bad;
    logic [MAX_RANK-1:0]     seen;
    logic [EB_W-1:0]         ebytes;

    always_comb
    begin
        logic [RIDX_W-1:0] fi;
        dim_t              v;
        if (rank_reg == '0)
            r = RANK_W'(1);
        else if (rank_reg > RANK_W'(MAX_RANK))
            r = RANK_W'(MAX_RANK);
        else
            r = rank_reg;
        for (int d = 0; d < MAX_RANK; d++)
        begin
            fi = RIDX_W'(r - RANK_W'(1) - RANK_W'(d));
            v  = dim_t'(dims_reg >> (fi * DIM_BITS));
            if (d < r && v != '0)
                indim[d] = v;
            else
                indim[d] = dim_t'(1);
        end
        any = 1'b0;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            raw[i] = axes_reg[i*AX_BITS +: AX_BITS];
            if (i < r && raw[i] != '0)
                any = 1'b1;
        end
        bad  = 1'b0;
        seen = '0;
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (i < r && any)
            begin
                if (RANK_W'(raw[i]) >= r || seen[raw[i]])
                    bad = 1'b1;
                else
                    seen[raw[i]] = 1'b1;
            end
        end
        for (int i = 0; i < MAX_RANK; i++)
        begin
            if (!any && r >= RANK_W'(2) && RANK_W'(i) == r - RANK_W'(1))
                ax[i] = axis_t'(r - RANK_W'(2));
            else if (!any && r >= RANK_W'(2) && RANK_W'(i) == r - RANK_W'(2))
                ax[i] = axis_t'(r - RANK_W'(1));
            else if (any && !bad)
                ax[i] = raw[i];
            else
                ax[i] = axis_t'(i);
            od[i] = (i < r) ? indim[ax[i]] : dim_t'(1);
        end
        if (eb_reg == '0)
            ebytes = EB_W'(1);
        else if (eb_reg > EB_W'(8))
            ebytes = EB_W'(8);
        else
            ebytes = eb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_LOAD;
            rank_reg  <= RANK_RST;
            dims_reg  <= DIMS_RST;
            axes_reg  <= AXES_RST;
            eb_reg    <= EBYTES_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                state_reg <= C_LOAD;
                unique case (reg_idx_t'(cfg_index))
                    REG_RANK:   rank_reg <= cfg_data[RANK_W-1:0];
                    REG_DIMS:   dims_reg <= cfg_data;
                    REG_AXES:   axes_reg <= cfg_data[AXES_W-1:0];
                    REG_EBYTES: eb_reg   <= cfg_data[EB_W-1:0];
                    default:    ;
                endcase
            end
            else
            begin
                unique case (state_reg)
                    C_IDLE: ;
                    C_LOAD:
                    begin
                        r_reg      <= r;
                        bad_reg    <= bad;
                        ebytes_reg <= ebytes;
                        ax_reg     <= ax;
                        od_reg     <= od;
                        indim_reg  <= indim;
                        k_reg      <= RIDX_W'(r - RANK_W'(1));
                        for (int i = 0; i < MAX_RANK; i++)
                        begin
                            src_reg[i] <= (RANK_W'(i) == r - RANK_W'(1)) ? idx_t'(1) : '0;
                            dst_reg[i] <= (RANK_W'(i) == r - RANK_W'(1)) ? idx_t'(1) : '0;
                        end
                        state_reg <= C_STEP;
                    end
                    C_STEP:
                    begin
                        if (k_reg == '0)
                        begin
                            total_reg <= idx_t'(dst_reg[0] * od_reg[0]);
                            state_reg <= C_IDLE;
                        end
                        else
                        begin
                            src_reg[k_reg - 1'b1] <= idx_t'(src_reg[k_reg] * indim_reg[k_reg]);
                            dst_reg[k_reg - 1'b1] <= idx_t'(dst_reg[k_reg] * od_reg[k_reg]);
                            k_reg <= k_reg - 1'b1;
                        end
                    end
                    default: state_reg <= C_IDLE;
                endcase
            end
        end
    end

    always_comb
    begin
        geom.busy   = (state_reg != C_IDLE);
        geom.rank   = r_reg;
        geom.bad    = bad_reg;
        geom.ebytes = ebytes_reg;
        geom.ax     = ax_reg;
        geom.od     = od_reg;
        geom.src    = src_reg;
        geom.dst    = dst_reg;
        geom.total  = total_reg;
    end

endmodule

### sv/npag_front.sv
module npag_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 busy,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 op,
    input  npag_pkg::idx_t       position,
    output logic                 q_valid,
    output npag_pkg::item_t      q_item,
    input  logic                 q_pop
);
    import npag_pkg::*;

    item_t        mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         push;

    assign in_stall = busy || (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= '{op: op, position: position};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !q_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (q_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

### sv/npag_back.sv
module npag_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  npag_pkg::geom_t                     geom,
    input  logic                                q_valid,
    input  npag_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [npag_pkg::IDX_W-1:0]          out_index,
    output logic [npag_pkg::IDX_W-1:0]          in_index,
    output logic [npag_pkg::BYTE_W-1:0]         src_byte_offset,
    output logic [npag_pkg::BYTE_W-1:0]         dst_byte_offset,
    output logic                                last,
    output logic                                bad_perm
);
    import npag_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_PROD, B_SUM, B_EMIT} bstate_t;

    bstate_t                 state_reg;
    dim_t  [MAX_RANK-1:0]    coord_reg;
    dim_t  [MAX_RANK-1:0]    coord_next;
    idx_t                    lp_reg;
    idx_t  [MAX_RANK-1:0]    prod_reg;
    idx_t                    in_idx_reg;
    logic                    last_reg;
    idx_t                    dvd_reg;
    idx_t                    rem_reg;
    idx_t                    quot_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [RIDX_W-1:0]       d_reg;
    logic                    mod_reg;
    logic                    out_valid_reg;
    idx_t                    out_index_reg;
    idx_t                    in_index_reg;
    logic [BYTE_W-1:0]       src_off_reg;
    logic [BYTE_W-1:0]       dst_off_reg;
    logic                    out_last_reg;
    logic                    bad_reg;

    idx_t                    divisor;
    logic [IDX_W:0]          shifted;
    logic [IDX_W:0]          diff;
    idx_t                    rem_step;
    idx_t                    quot_step;
    idx_t                    sum;
    logic                    out_free;

    assign q_pop    = (state_reg == B_IDLE) && q_valid && !geom.busy;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        divisor = mod_reg ? geom.total : geom.dst[d_reg];
        shifted = {rem_reg, dvd_reg[IDX_W-1]};
        diff    = shifted - {1'b0, divisor};
        if (!diff[IDX_W])
        begin
            rem_step  = diff[IDX_W-1:0];
            quot_step = {quot_reg[IDX_W-2:0], 1'b1};
        end
        else
        begin
            rem_step  = shifted[IDX_W-1:0];
            quot_step = {quot_reg[IDX_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        logic carry;
        dim_t c;
        carry = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--)
        begin
            c             = coord_reg[d] + dim_t'(1);
            coord_next[d] = coord_reg[d];
            if (d < geom.rank && carry)
            begin
                if (c < geom.od[d])
                begin
                    coord_next[d] = c;
                    carry         = 1'b0;
                end
                else
                    coord_next[d] = '0;
            end
        end
        sum = '0;
        for (int d = 0; d < MAX_RANK; d++)
            sum = sum + prod_reg[d];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            coord_reg     <= '0;
            lp_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != B_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (geom.busy)
                    begin
                        coord_reg <= '0;
                        lp_reg    <= '0;
                    end
                    else if (q_valid)
                    begin
                        if (!q_item.op)
                        begin
                            dvd_reg   <= q_item.position;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            mod_reg   <= 1'b1;
                            d_reg     <= '0;
                            state_reg <= B_DIV;
                        end
                        else
                            state_reg <= B_PROD;
                    end
                end
                B_DIV:
                begin
                    quot_reg <= quot_step;
                    if (cnt_reg == CNT_W'(IDX_W - 1))
                    begin
                        rem_reg <= '0;
                        cnt_reg <= '0;
                        dvd_reg <= rem_step;
                        if (mod_reg)
                        begin
                            lp_reg  <= rem_step;
                            mod_reg <= 1'b0;
                        end
                        else
                        begin
                            coord_reg[d_reg] <= quot_step[DIM_BITS-1:0];
                            if (RANK_W'(d_reg) == geom.rank - RANK_W'(1))
                                state_reg <= B_PROD;
                            else
                                d_reg <= d_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[IDX_W-2:0], 1'b0};
                        rem_reg <= rem_step;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                B_PROD:
                begin
                    for (int d = 0; d < MAX_RANK; d++)
                        prod_reg[d] <= (d < geom.rank)
                            ? idx_t'(coord_reg[d] * geom.src[geom.ax[d]]) : '0;
                    last_reg  <= (lp_reg == geom.total - idx_t'(1));
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    in_idx_reg <= sum;
                    state_reg  <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= lp_reg;
                        in_index_reg  <= in_idx_reg;
                        src_off_reg   <= BYTE_W'(in_idx_reg) * BYTE_W'(geom.ebytes);
                        dst_off_reg   <= BYTE_W'(lp_reg) * BYTE_W'(geom.ebytes);
                        out_last_reg  <= last_reg;
                        bad_reg       <= geom.bad;
                        coord_reg     <= coord_next;
                        lp_reg        <= last_reg ? '0 : lp_reg + idx_t'(1);
                        state_reg     <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_index       = out_index_reg;
    assign in_index        = in_index_reg;
    assign src_byte_offset = src_off_reg;
    assign dst_byte_offset = dst_off_reg;
    assign last            = out_last_reg;
    assign bad_perm        = bad_reg;

endmodule

### sv/nd_permute_address_generator_unit.sv
// An advance word goes from the queue through B_PROD, B_SUM and B_EMIT to out_valid;
// a seek word first runs (rank + 1) divisions of the shift-subtract divider.
// The back end takes a new word only once the last is emitted; out_stall holds B_EMIT.
// A two-word queue decouples input acceptance from the back end.
// Reset (async, rst_n low) loads the default registers and derives strides;
// in_stall stays high after reset or any register write while strides are derived.
module nd_permute_address_generator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [npag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [npag_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [npag_pkg::IDX_W-1:0]          position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [npag_pkg::IDX_W-1:0]          out_index,
    output logic [npag_pkg::IDX_W-1:0]          in_index,
    output logic [npag_pkg::BYTE_W-1:0]         src_byte_offset,
    output logic [npag_pkg::BYTE_W-1:0]         dst_byte_offset,
    output logic                                last,
    output logic                                bad_perm
);
    import npag_pkg::*;

    geom_t   geom;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;

    npag_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    npag_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (geom.busy),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .position (position),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    npag_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .geom            (geom),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_index       (out_index),
        .in_index        (in_index),
        .src_byte_offset (src_byte_offset),
        .dst_byte_offset (dst_byte_offset),
        .last            (last),
        .bad_perm        (bad_perm)
    );

endmodule

### sv/npag_checker.sv
module npag_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [npag_pkg::IDX_W-1:0]          out_index,
    input  logic [npag_pkg::IDX_W-1:0]          in_index,
    input  logic [npag_pkg::BYTE_W-1:0]         src_byte_offset,
    input  logic [npag_pkg::BYTE_W-1:0]         dst_byte_offset
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_index))
        else $error("output word dropped or changed under stall");

    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> in_stall)
        else $error("input accepted while strides rederive");

    a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_index == '0 |-> src_byte_offset == '0)
        else $error("source offset nonzero for index zero");

    a_dst_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_index == '0 |-> dst_byte_offset == '0)
        else $error("destination offset nonzero for index zero");

endmodule

bind nd_permute_address_generator_unit npag_checker u_npag_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_index       (out_index),
    .in_index        (in_index),
    .src_byte_offset (src_byte_offset),
    .dst_byte_offset (dst_byte_offset)
);
